### rtl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants of the rational arithmetic unit
// operation codes, sequencer states and datapath widths
// ----------------------------------------------------------------------------
package rau_pkg;

    // default operand width of the input fractions
    localparam int IN_WIDTH_DEF = 16;
    // width of the operation code
    localparam int CMD_W        = 3;
    // width of the intermediate products and sums
    localparam int DATA_W       = 64;
    // width of each result field
    localparam int RES_W        = 32;
    // number of compare flags
    localparam int FLAG_W       = 3;

    // operation codes
    typedef enum logic [CMD_W-1:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_MUL = 3'd2,
        CMD_DIV = 3'd3,
        CMD_CMP = 3'd4,
        CMD_NEG = 3'd5
    } t_cmd;

    // flag positions in the result side-band
    localparam int FLAG_LESS    = 0;
    localparam int FLAG_EQUAL   = 1;
    localparam int FLAG_GREATER = 2;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_PREP,
        ST_RED,
        ST_GCD,
        ST_DIVN_GO,
        ST_DIVN,
        ST_DIVD_GO,
        ST_DIVD,
        ST_FIN
    } t_state;

endpackage

### rtl/rau_mul.sv
// ----------------------------------------------------------------------------
// rau_mul: shared signed multiplier
// one operand pair per cycle, product registered and sign-extended to 64 bits
// ----------------------------------------------------------------------------
module rau_mul
    import rau_pkg::*;
#(
    parameter int IN_WIDTH = IN_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic signed [IN_WIDTH-1:0] i_x,
    input  logic signed [IN_WIDTH-1:0] i_y,
    output logic signed [DATA_W-1:0]  o_prod
);

    logic signed [2*IN_WIDTH-1:0] w_prod;
    logic signed [DATA_W-1:0]     r_prod;

    // full-width signed product
    assign w_prod = i_x * i_y;

    // product register
    always_ff @(posedge i_clk) begin
        r_prod <= DATA_W'(w_prod);
    end

    assign o_prod = r_prod;

endmodule

### rtl/rau_gcd.sv
// ----------------------------------------------------------------------------
// rau_gcd: iterative binary gcd
// one halving or subtract-and-halve step per cycle on two nonzero magnitudes
// ----------------------------------------------------------------------------
module rau_gcd
    import rau_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DATA_W-1:0] i_x,
    input  logic [DATA_W-1:0] i_y,
    output logic              o_done,
    output logic [DATA_W-1:0] o_gcd
);

    localparam int K_W = $clog2(DATA_W);

    logic              r_busy;
    logic [DATA_W-1:0] r_x;
    logic [DATA_W-1:0] r_y;
    logic [K_W-1:0]    r_k;
    logic              w_fin;
    logic              w_ge;
    logic [DATA_W-1:0] w_diff;

    // finished once either operand reaches zero
    assign w_fin  = (r_x == '0) || (r_y == '0);
    assign o_done = r_busy && w_fin;
    assign o_gcd  = (r_x | r_y) << r_k;

    // single subtractor, larger minus smaller
    assign w_ge   = (r_x >= r_y);
    assign w_diff = w_ge ? (r_x - r_y) : (r_y - r_x);

    // busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end

    // operand registers and common power of two
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_x;
            r_y <= i_y;
            r_k <= '0;
        end else if (r_busy && !w_fin) begin
            if (!r_x[0] && !r_y[0]) begin
                r_x <= r_x >> 1;
                r_y <= r_y >> 1;
                r_k <= r_k + K_W'(1);
            end else if (!r_x[0]) begin
                r_x <= r_x >> 1;
            end else if (!r_y[0]) begin
                r_y <= r_y >> 1;
            end else if (w_ge) begin
                r_x <= w_diff >> 1;
            end else begin
                r_y <= w_diff >> 1;
            end
        end
    end

endmodule

### rtl/rau_div.sv
// ----------------------------------------------------------------------------
// rau_div: serial restoring divider
// one quotient bit per cycle, shared by the numerator and denominator passes
// ----------------------------------------------------------------------------
module rau_div
    import rau_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DATA_W-1:0] i_dividend,
    input  logic [DATA_W-1:0] i_divisor,
    output logic              o_done,
    output logic [DATA_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(DATA_W + 1);

    logic              r_busy;
    logic [CNT_W-1:0]  r_cnt;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_quo;
    logic [DATA_W-1:0] r_dsr;
    logic [DATA_W:0]   w_sh;
    logic [DATA_W+1:0] w_diff;
    logic              w_ge;

    // shift in next dividend bit and trial subtract
    assign w_sh   = {r_rem, r_quo[DATA_W-1]};
    assign w_diff = {1'b0, w_sh} - {2'b00, r_dsr};
    assign w_ge   = !w_diff[DATA_W+1];

    assign o_done = r_busy && (r_cnt == '0);
    assign o_quo  = r_quo;

    // busy flag and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(DATA_W);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    // remainder and quotient shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy && (r_cnt != '0)) begin
            r_rem <= w_ge ? w_diff[DATA_W-1:0] : w_sh[DATA_W-1:0];
            r_quo <= {r_quo[DATA_W-2:0], w_ge};
        end
    end

endmodule

### rtl/rational_arithmetic_unit.sv
// Every request runs three multiplier passes, then prep; compare, negate and unused codes
// finish there. Add, subtract, multiply and divide go on to a binary gcd of one step per
// cycle and two serial divisions on one divider, both of which a zero numerator skips.
// One request at a time; a new one is taken while the last result waits at the output.
// Reset (synchronous, active low) returns the sequencer to idle and empties the output.
// ----------------------------------------------------------------------------
// rational_arithmetic_unit: fraction add, subtract, multiply, divide, compare, negate
// sequencer around a shared multiplier, a binary gcd unit and a serial divider
// ----------------------------------------------------------------------------
module rational_arithmetic_unit
    import rau_pkg::*;
#(
    parameter int IN_WIDTH = IN_WIDTH_DEF,
    localparam int S_TDATA_W = ((CMD_W + 4 * IN_WIDTH + 7) / 8) * 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // cmd, a_num, a_den, b_num, b_den, zero fill
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // res_num, res_den
    output logic [2*RES_W-1:0]   o_m_axis_tdata,
    // less, equal, greater
    output logic [FLAG_W-1:0]    o_m_axis_tuser
);

    t_state r_state;
    t_state n_state;

    logic [CMD_W-1:0]           r_cmd;
    logic signed [IN_WIDTH-1:0] r_an;
    logic signed [IN_WIDTH-1:0] r_ad;
    logic signed [IN_WIDTH-1:0] r_bn;
    logic signed [IN_WIDTH-1:0] r_bd;
    logic signed [IN_WIDTH-1:0] w_in_ad;
    logic signed [IN_WIDTH-1:0] w_in_bd;

    logic signed [IN_WIDTH-1:0] w_mul_x;
    logic signed [IN_WIDTH-1:0] w_mul_y;
    logic signed [DATA_W-1:0]   w_prod;
    logic signed [DATA_W-1:0]   r_p0;
    logic signed [DATA_W-1:0]   r_p1;
    logic [FLAG_W-1:0]          w_cmp_flags;

    logic signed [DATA_W-1:0]   w_an64;
    logic signed [DATA_W-1:0]   w_ad64;
    logic signed [DATA_W-1:0]   w_bn64;
    logic [DATA_W-1:0]          r_n;
    logic [DATA_W-1:0]          r_d;
    logic [DATA_W-1:0]          w_d_fix;
    logic [DATA_W-1:0]          w_mn;
    logic [DATA_W-1:0]          w_md;
    logic [DATA_W-1:0]          r_mn;
    logic [DATA_W-1:0]          r_md;
    logic                       r_nneg;
    logic                       r_dneg;
    logic [DATA_W-1:0]          r_g;

    logic                       w_gcd_start;
    logic                       w_gcd_done;
    logic [DATA_W-1:0]          w_gcd;
    logic                       w_div_start;
    logic [DATA_W-1:0]          w_dividend;
    logic                       w_div_done;
    logic [DATA_W-1:0]          w_quo;

    logic [RES_W-1:0]           r_res_num;
    logic [RES_W-1:0]           r_res_den;
    logic [FLAG_W-1:0]          r_flags;
    logic [RES_W-1:0]           r_o_num;
    logic [RES_W-1:0]           r_o_den;
    logic [FLAG_W-1:0]          r_o_flags;
    logic                       r_out_valid;
    logic                       w_in_accept;
    logic                       w_out_load;

    // request handshake
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_in_accept     = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_load      = (r_state == ST_FIN) && (!r_out_valid || i_m_axis_tready);

    // zero denominators taken as one
    assign w_in_ad = (i_s_axis_tdata[CMD_W+IN_WIDTH +: IN_WIDTH] == '0)
                   ? IN_WIDTH'(1) : i_s_axis_tdata[CMD_W+IN_WIDTH +: IN_WIDTH];
    assign w_in_bd = (i_s_axis_tdata[CMD_W+3*IN_WIDTH +: IN_WIDTH] == '0)
                   ? IN_WIDTH'(1) : i_s_axis_tdata[CMD_W+3*IN_WIDTH +: IN_WIDTH];

    // sign-extended operands
    assign w_an64 = DATA_W'(r_an);
    assign w_ad64 = DATA_W'(r_ad);
    assign w_bn64 = DATA_W'(r_bn);

    // multiplier operand selection per pass
    always_comb begin
        w_mul_x = r_ad;
        w_mul_y = r_bd;
        case (r_state)
            ST_MUL0: begin
                w_mul_x = r_an;
                w_mul_y = (r_cmd == CMD_MUL) ? r_bn : r_bd;
            end
            ST_MUL1: begin
                w_mul_x = (r_cmd == CMD_MUL) ? r_ad : r_bn;
                w_mul_y = (r_cmd == CMD_MUL) ? r_bd : r_ad;
            end
            default: begin
                w_mul_x = r_ad;
                w_mul_y = r_bd;
            end
        endcase
    end

    rau_mul #(
        .IN_WIDTH (IN_WIDTH)
    ) u_mul (
        .i_clk  (i_clk),
        .i_x    (w_mul_x),
        .i_y    (w_mul_y),
        .o_prod (w_prod)
    );

    // compare flags from the two cross products
    always_comb begin
        w_cmp_flags               = '0;
        w_cmp_flags[FLAG_LESS]    = (r_p0 < r_p1);
        w_cmp_flags[FLAG_EQUAL]   = (r_p0 == r_p1);
        w_cmp_flags[FLAG_GREATER] = (r_p0 > r_p1);
    end

    // zero denominator after the product taken as one
    assign w_d_fix = (r_d == '0) ? DATA_W'(1) : r_d;

    // magnitudes for the reduction
    assign w_mn = r_n[DATA_W-1] ? (-r_n) : r_n;
    assign w_md = w_d_fix[DATA_W-1] ? (-w_d_fix) : w_d_fix;

    rau_gcd u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_gcd_start),
        .i_x     (w_mn),
        .i_y     (w_md),
        .o_done  (w_gcd_done),
        .o_gcd   (w_gcd)
    );

    // numerator pass first, then denominator pass
    assign w_dividend = (r_state == ST_DIVN_GO) ? r_mn : r_md;

    rau_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_g),
        .o_done     (w_div_done),
        .o_quo      (w_quo)
    );

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and unit starts
    always_comb begin
        n_state     = r_state;
        w_gcd_start = 1'b0;
        w_div_start = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_in_accept) begin
                    n_state = ST_MUL0;
                end
            end
            ST_MUL0: n_state = ST_MUL1;
            ST_MUL1: n_state = ST_MUL2;
            ST_MUL2: n_state = ST_PREP;
            ST_PREP: begin
                case (r_cmd)
                    CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: n_state = ST_RED;
                    default:                            n_state = ST_FIN;
                endcase
            end
            ST_RED: begin
                if (r_n == '0) begin
                    n_state = ST_FIN;
                end else begin
                    n_state = ST_GCD;
                end
            end
            ST_GCD: begin
                if (w_gcd_done) begin
                    n_state = ST_DIVN_GO;
                end
            end
            ST_DIVN_GO: begin
                w_div_start = 1'b1;
                n_state     = ST_DIVN;
            end
            ST_DIVN: begin
                if (w_div_done) begin
                    n_state = ST_DIVD_GO;
                end
            end
            ST_DIVD_GO: begin
                w_div_start = 1'b1;
                n_state     = ST_DIVD;
            end
            ST_DIVD: begin
                if (w_div_done) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        // gcd starts as the magnitudes are registered
        if ((r_state == ST_RED) && (r_n != '0)) begin
            w_gcd_start = 1'b1;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_in_accept) begin
                    r_cmd <= i_s_axis_tdata[CMD_W-1:0];
                    r_an  <= i_s_axis_tdata[CMD_W +: IN_WIDTH];
                    r_ad  <= w_in_ad;
                    r_bn  <= i_s_axis_tdata[CMD_W+2*IN_WIDTH +: IN_WIDTH];
                    r_bd  <= w_in_bd;
                end
            end
            ST_MUL1: r_p0 <= w_prod;
            ST_MUL2: r_p1 <= w_prod;
            ST_PREP: begin
                // negate and compare finish here, the rest start as 0/1
                r_res_num <= (r_cmd == CMD_NEG) ? RES_W'(-w_an64) : '0;
                r_res_den <= (r_cmd == CMD_NEG) ? RES_W'(w_ad64) : RES_W'(1);
                r_flags   <= (r_cmd == CMD_CMP) ? w_cmp_flags : '0;
                case (r_cmd)
                    CMD_ADD: begin
                        if (r_ad == r_bd) begin
                            r_d <= w_ad64;
                            r_n <= w_an64 + w_bn64;
                        end else begin
                            r_d <= w_prod;
                            r_n <= r_p0 + r_p1;
                        end
                    end
                    CMD_SUB: begin
                        if (r_ad == r_bd) begin
                            r_d <= w_ad64;
                            r_n <= w_an64 - w_bn64;
                        end else begin
                            r_d <= w_prod;
                            r_n <= r_p0 - r_p1;
                        end
                    end
                    CMD_MUL, CMD_DIV: begin
                        r_n <= r_p0;
                        r_d <= r_p1;
                    end
                    default: begin
                        r_n <= '0;
                        r_d <= DATA_W'(1);
                    end
                endcase
            end
            ST_RED: begin
                // signs and magnitudes for the reduction
                r_nneg <= r_n[DATA_W-1];
                r_dneg <= w_d_fix[DATA_W-1];
                r_mn   <= w_mn;
                r_md   <= w_md;
                r_g    <= '0;
            end
            ST_GCD: begin
                if (w_gcd_done) begin
                    r_g <= w_gcd;
                end
            end
            ST_DIVN: begin
                if (w_div_done) begin
                    r_res_num <= r_nneg ? (-w_quo[RES_W-1:0]) : w_quo[RES_W-1:0];
                end
            end
            ST_DIVD: begin
                if (w_div_done) begin
                    r_res_den <= r_dneg ? (-w_quo[RES_W-1:0]) : w_quo[RES_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    // output register, freed by the downstream handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_o_num   <= r_res_num;
            r_o_den   <= r_res_den;
            r_o_flags <= r_flags;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_o_den, r_o_num};
    assign o_m_axis_tuser  = r_o_flags;

    // an accepted request starts the first multiplier pass
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> (r_state == ST_MUL0))
        else $error("request accepted but multiplier pass not started");

    // the gcd of two nonzero magnitudes is nonzero
    a_gcd_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_gcd_done |-> (w_gcd != '0))
        else $error("gcd unit returned zero");

    // at most one compare flag, and a set flag goes with 0/1
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ($onehot0(o_m_axis_tuser)
            && ((o_m_axis_tuser == '0) || ((r_o_num == '0) && (r_o_den == RES_W'(1))))))
        else $error("compare flags inconsistent with result");

endmodule
